// ----- hdl/polyline_to_bezier_controls_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef POLYLINE_TO_BEZIER_CONTROLS_DEFINES_SVH
`define POLYLINE_TO_BEZIER_CONTROLS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBC_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pbc check failed");

// Next-cycle implication, disabled during reset.
`define PBC_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pbc check failed");

`endif

// ----- hdl/pbc_pkg.sv -----
package pbc_pkg;

  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd1365;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HANDLE   = 2'd0,
    KIND_IN_CTRL  = 2'd1,
    KIND_OUT_CTRL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_FIRST,
    CMD_REJECT,
    CMD_SECOND,
    CMD_INTERIOR
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
    logic pe;
  } job_ctl_t;

  typedef enum logic [2:0] {
    PH_IN_PREV,
    PH_HANDLE_PREV,
    PH_OUT_PREV,
    PH_IN_LAST,
    PH_HANDLE_LAST,
    PH_SINGLE
  } phase_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ADD,
    OP_SUB
  } op_t;

endpackage

// ----- hdl/pbc_front.sv -----
`include "polyline_to_bezier_controls_defines.svh"

module pbc_front import pbc_pkg::*; #(
  parameter int COORD_BITS         = 20,
  parameter int SEGMENTS_PER_PIECE = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic                         last_point,
  input  logic                         full,
  output logic                         push,
  output job_ctl_t                     ctl,
  output logic signed [COORD_BITS-1:0] hold_x,
  output logic signed [COORD_BITS-1:0] hold_y,
  output logic signed [COORD_BITS:0]   dprev_x,
  output logic signed [COORD_BITS:0]   dprev_y,
  output logic signed [COORD_BITS:0]   dlast_x,
  output logic signed [COORD_BITS:0]   dlast_y
);

  localparam int SEG_BITS = $clog2(SEGMENTS_PER_PIECE + 1);

  logic signed [COORD_BITS-1:0] older_x, older_y, newer_x, newer_y;
  logic [1:0]                   points_seen;
  logic [SEG_BITS-1:0]          seg_count;
  logic [SEG_BITS-1:0]          seg_inc;
  logic                         seg_wrap;

  assign in_stall = full;
  assign push     = in_valid && !full;
  assign hold_x   = newer_x;
  assign hold_y   = newer_y;

  assign seg_inc  = seg_count + 1'b1;
  assign seg_wrap = seg_inc >= SEG_BITS'(SEGMENTS_PER_PIECE);

  assign dlast_x = {x[COORD_BITS-1], x} - {newer_x[COORD_BITS-1], newer_x};
  assign dlast_y = {y[COORD_BITS-1], y} - {newer_y[COORD_BITS-1], newer_y};

  always_comb begin
    ctl.last = last_point;
    ctl.pe   = 1'b0;
    dprev_x  = dlast_x;
    dprev_y  = dlast_y;
    case (points_seen)
      2'd0: begin
        ctl.cmd = last_point ? CMD_REJECT : CMD_FIRST;
      end
      2'd1: begin
        ctl.cmd = CMD_SECOND;
      end
      default: begin
        ctl.cmd = CMD_INTERIOR;
        ctl.pe  = seg_wrap;
        dprev_x = {x[COORD_BITS-1], x} - {older_x[COORD_BITS-1], older_x};
        dprev_y = {y[COORD_BITS-1], y} - {older_y[COORD_BITS-1], older_y};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      seg_count   <= '0;
      older_x     <= '0;
      older_y     <= '0;
      newer_x     <= '0;
      newer_y     <= '0;
    end else if (push) begin
      if (points_seen == 2'd0) begin
        seg_count <= '0;
        if (!last_point) begin
          newer_x     <= x;
          newer_y     <= y;
          points_seen <= 2'd1;
        end
      end else if (last_point) begin
        points_seen <= 2'd0;
        seg_count   <= '0;
        older_x     <= '0;
        older_y     <= '0;
        newer_x     <= '0;
        newer_y     <= '0;
      end else begin
        if (points_seen == 2'd2) begin
          seg_count <= seg_wrap ? '0 : seg_inc;
        end
        older_x     <= newer_x;
        older_y     <= newer_y;
        newer_x     <= x;
        newer_y     <= y;
        points_seen <= 2'd2;
      end
    end
  end

  `PBC_ASSERT_IMP(a_points_range, clk, rst, 1'b1, points_seen != 2'd3)
  `PBC_ASSERT_IMP(a_seg_range, clk, rst, 1'b1, seg_count < SEG_BITS'(SEGMENTS_PER_PIECE))
  `PBC_ASSERT_NXT(a_last_clears, clk, rst, push && last_point, points_seen == 2'd0 && seg_count == '0)

endmodule

// ----- hdl/pbc_fifo.sv -----
module pbc_fifo #(
  parameter int DATA_BITS = 170,
  parameter int DEPTH     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] din,
  output logic                 full,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] dout,
  output logic                 q_valid
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]  count;

  assign full    = count == CNT_BITS'(DEPTH);
  assign q_valid = count != '0;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/pbc_back.sv -----
`include "polyline_to_bezier_controls_defines.svh"

module pbc_back import pbc_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         gain_valid,
  output logic                         gain_ready,
  input  logic [GAIN_BITS-1:0]         gain,
  input  logic                         q_valid,
  output logic                         pop,
  input  job_ctl_t                     ctl,
  input  logic signed [COORD_BITS-1:0] hold_x,
  input  logic signed [COORD_BITS-1:0] hold_y,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic signed [COORD_BITS:0]   dprev_x,
  input  logic signed [COORD_BITS:0]   dprev_y,
  input  logic signed [COORD_BITS:0]   dlast_x,
  input  logic signed [COORD_BITS:0]   dlast_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [1:0]                   kind,
  output logic                         piece_end,
  output logic                         curve_last,
  output logic                         rejected
);

  localparam int PROD_BITS = COORD_BITS + 1 + GAIN_BITS;
  localparam int RND_BITS  = PROD_BITS - GAIN_FRAC + 1;
  localparam int SUM_BITS  = RND_BITS + 1;
  localparam int TOP_BITS  = SUM_BITS - COORD_BITS + 1;
  localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (GAIN_FRAC - 1);

  logic [GAIN_BITS-1:0] scale;

  // sequencer
  phase_t phase, phase_next, cur;
  logic   started, started_next;
  logic   adv, issue, final_step;

  // selection
  logic signed [COORD_BITS-1:0] sel_hx, sel_hy;
  logic signed [COORD_BITS:0]   sel_dx, sel_dy;
  logic [COORD_BITS:0]          mag_x, mag_y;
  op_t                          sel_op;
  kind_t                        sel_kind;
  logic                         sel_pe, sel_cl, sel_rej;

  // stage 1: product
  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_hx, s1_hy;
  logic [PROD_BITS-1:0]         s1_px, s1_py;
  logic                         s1_nx, s1_ny;
  op_t                          s1_op;
  kind_t                        s1_kind;
  logic                         s1_pe, s1_cl, s1_rej;

  // stage 2: rounded magnitude
  logic [PROD_BITS:0]           rsum_x, rsum_y;
  logic                         s2_valid;
  logic signed [COORD_BITS-1:0] s2_hx, s2_hy;
  logic [RND_BITS-1:0]          s2_rx, s2_ry;
  logic                         s2_subx, s2_suby, s2_pass;
  kind_t                        s2_kind;
  logic                         s2_pe, s2_cl, s2_rej;

  // stage 3: add and saturate
  logic signed [SUM_BITS-1:0]   sum_x, sum_y;
  logic [COORD_BITS-1:0]        sat_x, sat_y;
  kind_t                        res_kind;

  assign gain_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= GAIN_RESET;
    end else if (gain_valid) begin
      scale <= gain;
    end
  end

  assign adv   = !out_valid || !out_stall;
  assign issue = q_valid && adv;
  assign pop   = issue && final_step;

  always_comb begin
    if (started) begin
      cur = phase;
    end else begin
      case (ctl.cmd)
        CMD_SECOND:   cur = PH_OUT_PREV;
        CMD_INTERIOR: cur = PH_IN_PREV;
        default:      cur = PH_SINGLE;
      endcase
    end
    final_step = (cur == PH_SINGLE) || (cur == PH_HANDLE_LAST) ||
                 ((cur == PH_OUT_PREV) && !ctl.last);
    case (cur)
      PH_IN_PREV:     phase_next = PH_HANDLE_PREV;
      PH_HANDLE_PREV: phase_next = PH_OUT_PREV;
      PH_OUT_PREV:    phase_next = PH_IN_LAST;
      PH_IN_LAST:     phase_next = PH_HANDLE_LAST;
      default:        phase_next = PH_SINGLE;
    endcase
    started_next = started;
    if (issue) begin
      started_next = !final_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      phase   <= PH_SINGLE;
    end else begin
      started <= started_next;
      if (issue) begin
        phase <= phase_next;
      end
    end
  end

  always_comb begin
    sel_hx   = hold_x;
    sel_hy   = hold_y;
    sel_dx   = dprev_x;
    sel_dy   = dprev_y;
    sel_op   = OP_PASS;
    sel_kind = KIND_HANDLE;
    sel_pe   = 1'b0;
    sel_cl   = 1'b0;
    sel_rej  = 1'b0;
    case (cur)
      PH_IN_PREV: begin
        sel_op   = OP_SUB;
        sel_kind = KIND_IN_CTRL;
      end
      PH_HANDLE_PREV: begin
        sel_pe = ctl.pe;
      end
      PH_OUT_PREV: begin
        sel_op   = OP_ADD;
        sel_kind = KIND_OUT_CTRL;
      end
      PH_IN_LAST: begin
        sel_hx   = pt_x;
        sel_hy   = pt_y;
        sel_dx   = dlast_x;
        sel_dy   = dlast_y;
        sel_op   = OP_SUB;
        sel_kind = KIND_IN_CTRL;
      end
      PH_HANDLE_LAST: begin
        sel_hx = pt_x;
        sel_hy = pt_y;
        sel_cl = 1'b1;
      end
      default: begin
        sel_rej = ctl.cmd == CMD_REJECT;
        sel_cl  = ctl.cmd == CMD_REJECT;
        sel_hx  = (ctl.cmd == CMD_REJECT) ? '0 : pt_x;
        sel_hy  = (ctl.cmd == CMD_REJECT) ? '0 : pt_y;
        sel_dx  = '0;
        sel_dy  = '0;
      end
    endcase
    mag_x = sel_dx[COORD_BITS] ? (~sel_dx + {{COORD_BITS{1'b0}}, 1'b1}) : sel_dx;
    mag_y = sel_dy[COORD_BITS] ? (~sel_dy + {{COORD_BITS{1'b0}}, 1'b1}) : sel_dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hx   <= sel_hx;
      s1_hy   <= sel_hy;
      s1_px   <= PROD_BITS'(mag_x) * PROD_BITS'(scale);
      s1_py   <= PROD_BITS'(mag_y) * PROD_BITS'(scale);
      s1_nx   <= sel_dx[COORD_BITS];
      s1_ny   <= sel_dy[COORD_BITS];
      s1_op   <= sel_op;
      s1_kind <= sel_kind;
      s1_pe   <= sel_pe;
      s1_cl   <= sel_cl;
      s1_rej  <= sel_rej;
    end
  end

  assign rsum_x = {1'b0, s1_px} + ROUND_HALF;
  assign rsum_y = {1'b0, s1_py} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_hx   <= s1_hx;
      s2_hy   <= s1_hy;
      s2_rx   <= rsum_x[PROD_BITS:GAIN_FRAC];
      s2_ry   <= rsum_y[PROD_BITS:GAIN_FRAC];
      s2_subx <= (s1_op == OP_SUB) ^ s1_nx;
      s2_suby <= (s1_op == OP_SUB) ^ s1_ny;
      s2_pass <= s1_op == OP_PASS;
      s2_kind <= s1_kind;
      s2_pe   <= s1_pe;
      s2_cl   <= s1_cl;
      s2_rej  <= s1_rej;
    end
  end

  always_comb begin
    logic signed [SUM_BITS-1:0] hx_w, hy_w, mx_w, my_w;
    logic [TOP_BITS-1:0]        top_x, top_y;
    hx_w = {{(SUM_BITS - COORD_BITS){s2_hx[COORD_BITS-1]}}, s2_hx};
    hy_w = {{(SUM_BITS - COORD_BITS){s2_hy[COORD_BITS-1]}}, s2_hy};
    mx_w = s2_pass ? '0 : {1'b0, s2_rx};
    my_w = s2_pass ? '0 : {1'b0, s2_ry};
    sum_x = s2_subx ? (hx_w - mx_w) : (hx_w + mx_w);
    sum_y = s2_suby ? (hy_w - my_w) : (hy_w + my_w);
    top_x = sum_x[SUM_BITS-1:COORD_BITS-1];
    top_y = sum_y[SUM_BITS-1:COORD_BITS-1];
    if ((&top_x) || !(|top_x)) begin
      sat_x = sum_x[COORD_BITS-1:0];
    end else begin
      sat_x = sum_x[SUM_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    if ((&top_y) || !(|top_y)) begin
      sat_y = sum_y[COORD_BITS-1:0];
    end else begin
      sat_y = sum_y[SUM_BITS-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                : {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x      <= sat_x;
      out_y      <= sat_y;
      res_kind   <= s2_kind;
      piece_end  <= s2_pe;
      curve_last <= s2_cl;
      rejected   <= s2_rej;
    end
  end

  assign kind = res_kind;

  `PBC_ASSERT_IMP(a_reject_shape, clk, rst, out_valid && rejected, curve_last && res_kind == KIND_HANDLE)
  `PBC_ASSERT_IMP(a_junction_handle, clk, rst, out_valid && piece_end, res_kind == KIND_HANDLE && !curve_last)
  `PBC_ASSERT_IMP(a_started_has_head, clk, rst, started, q_valid)

endmodule

// ----- hdl/polyline_to_bezier_controls.sv -----
// Polyline to cubic Bezier control stream.
// Input channel (in_valid / in_stall): one polyline point per word, x and y
// signed with 4 fraction bits, last_point set on the final point.
// Output channel (out_valid / out_stall): one Bezier point per word, tagged
// with kind (handle, incoming or outgoing control point), piece_end,
// curve_last and rejected. A one-point polyline yields one rejected word.
// Gain port (gain_valid / gain_ready): 1/(3*tension), 12 fraction bits,
// always ready; write it only while the block is idle.
// A front end keeps the two-point window and queues one job per point
// (4-entry queue); the back end issues one output word per cycle, unless
// out_stall holds it, through a multiply, round and add/saturate pipeline.
// A point's first word passes the product, rounded-magnitude and output registers.
// An interior point yields three output words and a final point up to five;
// the back end's single word per cycle sets the pace.
// Reset: gain returns to 1365, the window and queue empty, outputs invalid.
// A stalled output holds its word and freezes the back end; the front keeps
// taking points until the queue fills, then raises in_stall.
module polyline_to_bezier_controls import pbc_pkg::*; #(
  parameter int SEGMENTS_PER_PIECE = 9,
  parameter int COORD_BITS         = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic                         last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic [1:0]                   kind,
  output logic                         piece_end,
  output logic                         curve_last,
  output logic                         rejected,
  input  logic                         gain_valid,
  output logic                         gain_ready,
  input  logic [GAIN_BITS-1:0]         gain
);

  localparam int JOB_BITS = 4 * COORD_BITS + 4 * (COORD_BITS + 1) + $bits(job_ctl_t);

  job_ctl_t                     f_ctl, b_ctl;
  logic                         push, full, pop, q_valid;
  logic signed [COORD_BITS-1:0] f_hold_x, f_hold_y, b_hold_x, b_hold_y;
  logic signed [COORD_BITS-1:0] b_pt_x, b_pt_y;
  logic signed [COORD_BITS:0]   f_dprev_x, f_dprev_y, f_dlast_x, f_dlast_y;
  logic signed [COORD_BITS:0]   b_dprev_x, b_dprev_y, b_dlast_x, b_dlast_y;
  logic [JOB_BITS-1:0]          q_din, q_dout;

  pbc_front #(
    .COORD_BITS         (COORD_BITS),
    .SEGMENTS_PER_PIECE (SEGMENTS_PER_PIECE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x          (x),
    .y          (y),
    .last_point (last_point),
    .full       (full),
    .push       (push),
    .ctl        (f_ctl),
    .hold_x     (f_hold_x),
    .hold_y     (f_hold_y),
    .dprev_x    (f_dprev_x),
    .dprev_y    (f_dprev_y),
    .dlast_x    (f_dlast_x),
    .dlast_y    (f_dlast_y)
  );

  assign q_din = {f_ctl, f_hold_x, f_hold_y, x, y,
                  f_dprev_x, f_dprev_y, f_dlast_x, f_dlast_y};

  pbc_fifo #(
    .DATA_BITS (JOB_BITS),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (q_din),
    .full    (full),
    .pop     (pop),
    .dout    (q_dout),
    .q_valid (q_valid)
  );

  assign {b_ctl, b_hold_x, b_hold_y, b_pt_x, b_pt_y,
          b_dprev_x, b_dprev_y, b_dlast_x, b_dlast_y} = q_dout;

  pbc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .gain_valid (gain_valid),
    .gain_ready (gain_ready),
    .gain       (gain),
    .q_valid    (q_valid),
    .pop        (pop),
    .ctl        (b_ctl),
    .hold_x     (b_hold_x),
    .hold_y     (b_hold_y),
    .pt_x       (b_pt_x),
    .pt_y       (b_pt_y),
    .dprev_x    (b_dprev_x),
    .dprev_y    (b_dprev_y),
    .dlast_x    (b_dlast_x),
    .dlast_y    (b_dlast_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .kind       (kind),
    .piece_end  (piece_end),
    .curve_last (curve_last),
    .rejected   (rejected)
  );

endmodule
